>>> rtl/capture_period_speed_meter_core_defines.svh
// Assertion macros shared by the speed meter checker.
`ifndef CAPTURE_PERIOD_SPEED_METER_CORE_DEFINES_SVH
`define CAPTURE_PERIOD_SPEED_METER_CORE_DEFINES_SVH

// Checked on every clock edge outside reset.
`define CPSM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every clock edge, reset cycles included.
`define CPSM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> rtl/cpsm_pkg.sv
// Shared types and constants of the capture period speed meter.
`default_nettype none

package cpsm_pkg;

    localparam logic [14:0] SPEED_MAX    = 15'h7FFF;
    localparam logic [12:0] Q12_ONE      = 13'd4096;
    localparam logic [3:0]  SAMPLE_SLOTS = 4'd10;

    // configuration register indexes
    localparam logic [2:0] REG_SPEED_NUMERATOR    = 3'd0;
    localparam logic [2:0] REG_PERIOD_UPPER_LIMIT = 3'd1;
    localparam logic [2:0] REG_PERIOD_LOWER_LIMIT = 3'd2;
    localparam logic [2:0] REG_FILTER_WEIGHT      = 3'd3;
    localparam logic [2:0] REG_JUMP_LIMIT         = 3'd4;
    localparam logic [2:0] REG_CHECK_SPEED_FLOOR  = 3'd5;
    localparam logic [2:0] REG_BUS_VOLTAGE_FLOOR  = 3'd6;

    // divider request and response
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [30:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [14:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

>>> rtl/cpsm_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle, quotient saturated to 15 bits.
`default_nettype none

module cpsm_divider
    import cpsm_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [30:0] rem_reg;
    logic [31:0] qd_reg;      // dividend shifts out the top, quotient in at the bottom
    logic [30:0] dvs_reg;

    logic [31:0] trial;
    logic        fits;
    logic [31:0] trial_sub;

    always_comb begin
        trial     = {rem_reg, qd_reg[31]};
        fits      = trial >= {1'b0, dvs_reg};
        trial_sub = trial - {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start && !busy_reg) begin
            rem_reg <= 31'd0;
            qd_reg  <= req.dividend;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so 31 bits hold it
            rem_reg <= fits ? trial_sub[30:0] : trial[30:0];
            qd_reg  <= {qd_reg[30:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = (qd_reg[31:15] != 17'd0) ? SPEED_MAX : qd_reg[14:0];

endmodule

`default_nettype wire

>>> rtl/capture_period_speed_meter_core.sv
// Capture period speed meter: period from timer captures, speed by division, Q12 low-pass.
//
// Usage:
//   s_axis carries one timer event per request: tuser holds the overflow and
//   capture flags, tdata the two capture values and the bus voltage sample.
//   m_axis returns one result per event: raw speed, filtered speed, ring slot
//   and the period used for the division.
//   cfg_wr_en/cfg_addr/cfg_wdata write the seven setup registers; write them
//   only while no event is in flight.
// Timing:
//   An event runs through a small sequencer and one restoring divider
//   (one quotient bit per cycle). The result shows on m_axis after the sequencer
//   reaches its last step; when the period is zero the division is skipped and
//   the speed is set to its maximum. s_axis_tready is low while an event is in
//   work, so a new event is taken only after the last one has left the sequencer.
//   The result sits in an output register; a new event is accepted while it
//   waits. If the receiver stalls, the next result waits in the last step until
//   the output register frees up.
// Reset: aresetn (synchronous, active low) clears the history state and loads
//   the setup registers with their defaults; m_axis_tvalid drops at the next edge.
`default_nettype none

module capture_period_speed_meter_core
    import cpsm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write port
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [31:0] cfg_wdata,
    // event input
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // capture_now[15:0], capture_prev[31:16],
                                            // bus_voltage[43:32], zero pad
    input  wire logic [1:0]  s_axis_tuser,  // overflow_event[0], capture_event[1]
    // result output
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata   // speed_raw[14:0], speed_filtered[30:15],
                                            // ring_slot[34:31], period_used[65:35], zero pad
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_PERIOD   = 4'd1;
    localparam logic [3:0] ST_CLAMP    = 4'd2;
    localparam logic [3:0] ST_LOWER    = 4'd3;
    localparam logic [3:0] ST_DIV_GO   = 4'd4;
    localparam logic [3:0] ST_DIV_WAIT = 4'd5;
    localparam logic [3:0] ST_JUMP     = 4'd6;
    localparam logic [3:0] ST_MUL_OLD  = 4'd7;
    localparam logic [3:0] ST_MUL_NEW  = 4'd8;
    localparam logic [3:0] ST_DONE     = 4'd9;

    logic [3:0]  state_reg;

    // setup registers
    logic [31:0] speed_numerator_reg;
    logic [30:0] period_upper_limit_reg;
    logic [30:0] period_lower_limit_reg;
    logic [12:0] filter_weight_reg;
    logic [14:0] jump_limit_reg;
    logic [14:0] check_speed_floor_reg;
    logic [11:0] bus_voltage_floor_reg;

    // event payload
    logic        ovf_reg;
    logic        cap_reg;
    logic [15:0] cap_now_reg;
    logic [15:0] cap_prev_reg;
    logic [11:0] bus_reg;

    // history
    logic [15:0] overflow_count_reg;
    logic [31:0] active_period_reg;
    logic [30:0] held_period_reg;
    logic [14:0] prev_speed_reg;
    logic [15:0] filtered_reg;
    logic [3:0]  slot_index_reg;

    // work registers
    logic [31:0] clamped_reg;
    logic [30:0] period_reg;
    logic [14:0] speed_reg;
    logic [28:0] prod_reg;
    logic [3:0]  slot_reg;

    logic        m_tvalid_reg;
    logic [71:0] m_tdata_reg;

    div_req_t    div_req;
    div_rsp_t    div_rsp;

    logic [15:0] count_upd;
    logic [31:0] active_calc;
    logic [31:0] clamp_next;
    logic        below;
    logic [30:0] period_next;
    logic [14:0] speed_diff;
    logic        reject;
    logic [14:0] speed_fin;
    logic [12:0] weight;
    logic [15:0] mul_a;
    logic [12:0] mul_b;
    logic [28:0] mul_p;
    logic [29:0] filt_sum;
    logic [3:0]  slot_cur;
    logic [4:0]  slot_inc;
    logic        out_free;

    always_comb begin
        count_upd   = ovf_reg ? overflow_count_reg + 16'd1 : overflow_count_reg;
        active_calc = ({16'd0, cap_now_reg} - {16'd0, cap_prev_reg}) + {count_upd, 16'd0};

        // signed view: a negative period never clamps and always falls below
        clamp_next = (!active_period_reg[31] && active_period_reg[30:0] > period_upper_limit_reg)
                     ? {1'b0, period_upper_limit_reg} : active_period_reg;
        below       = clamped_reg[31] || (clamped_reg[30:0] < period_lower_limit_reg);
        period_next = below ? held_period_reg : clamped_reg[30:0];

        speed_diff = (speed_reg > prev_speed_reg) ? speed_reg - prev_speed_reg
                                                  : prev_speed_reg - speed_reg;
        reject     = (prev_speed_reg > check_speed_floor_reg) && (speed_diff > jump_limit_reg)
                     && (bus_reg > bus_voltage_floor_reg);
        speed_fin  = reject ? prev_speed_reg : speed_reg;

        weight = (filter_weight_reg > Q12_ONE) ? Q12_ONE : filter_weight_reg;
        if (state_reg == ST_MUL_OLD) begin
            mul_a = filtered_reg;
            mul_b = Q12_ONE - weight;
        end else begin
            mul_a = {1'b0, speed_reg};
            mul_b = weight;
        end
        mul_p    = 29'(mul_a) * 29'(mul_b);
        filt_sum = {1'b0, prod_reg} + {1'b0, mul_p};

        slot_cur = (slot_index_reg >= SAMPLE_SLOTS) ? 4'd0 : slot_index_reg;
        slot_inc = {1'b0, slot_cur} + 5'd1;

        out_free = !m_tvalid_reg || m_axis_tready;
    end

    assign div_req.start    = (state_reg == ST_DIV_GO) && (period_reg != 31'd0);
    assign div_req.dividend = speed_numerator_reg;
    assign div_req.divisor  = period_reg;

    cpsm_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // setup registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_numerator_reg    <= 32'd0;
            period_upper_limit_reg <= 31'h7FFF_FFFF;
            period_lower_limit_reg <= 31'd1;
            filter_weight_reg      <= 13'd1500;
            jump_limit_reg         <= 15'd350;
            check_speed_floor_reg  <= 15'd2262;
            bus_voltage_floor_reg  <= 12'd1430;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_SPEED_NUMERATOR:    speed_numerator_reg    <= cfg_wdata;
                REG_PERIOD_UPPER_LIMIT: period_upper_limit_reg <= cfg_wdata[30:0];
                REG_PERIOD_LOWER_LIMIT: period_lower_limit_reg <= cfg_wdata[30:0];
                REG_FILTER_WEIGHT:      filter_weight_reg      <= cfg_wdata[12:0];
                REG_JUMP_LIMIT:         jump_limit_reg         <= cfg_wdata[14:0];
                REG_CHECK_SPEED_FLOOR:  check_speed_floor_reg  <= cfg_wdata[14:0];
                REG_BUS_VOLTAGE_FLOOR:  bus_voltage_floor_reg  <= cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    // sequencer and history state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            overflow_count_reg <= 16'd0;
            active_period_reg  <= 32'd0;
            held_period_reg    <= 31'd0;
            prev_speed_reg     <= 15'd0;
            filtered_reg       <= 16'd0;
            slot_index_reg     <= 4'd0;
            m_tvalid_reg       <= 1'b0;
        end else begin
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_axis_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        state_reg <= ST_PERIOD;
                    end
                end
                ST_PERIOD: begin
                    if (cap_reg) begin
                        active_period_reg  <= active_calc;
                        overflow_count_reg <= 16'd0;
                    end else begin
                        overflow_count_reg <= count_upd;
                    end
                    state_reg <= ST_CLAMP;
                end
                ST_CLAMP: begin
                    state_reg <= ST_LOWER;
                end
                ST_LOWER: begin
                    held_period_reg <= period_next;
                    state_reg       <= ST_DIV_GO;
                end
                ST_DIV_GO: begin
                    state_reg <= (period_reg == 31'd0) ? ST_JUMP : ST_DIV_WAIT;
                end
                ST_DIV_WAIT: begin
                    if (div_rsp.done) begin
                        state_reg <= ST_JUMP;
                    end
                end
                ST_JUMP: begin
                    prev_speed_reg <= speed_fin;
                    state_reg      <= ST_MUL_OLD;
                end
                ST_MUL_OLD: begin
                    state_reg <= ST_MUL_NEW;
                end
                ST_MUL_NEW: begin
                    filtered_reg   <= filt_sum[27:12];
                    slot_index_reg <= (slot_inc >= {1'b0, SAMPLE_SLOTS}) ? 4'd0 : slot_inc[3:0];
                    state_reg      <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_axis_tvalid) begin
            ovf_reg      <= s_axis_tuser[0];
            cap_reg      <= s_axis_tuser[1];
            cap_now_reg  <= s_axis_tdata[15:0];
            cap_prev_reg <= s_axis_tdata[31:16];
            bus_reg      <= s_axis_tdata[43:32];
        end
        if (state_reg == ST_CLAMP) begin
            clamped_reg <= clamp_next;
        end
        if (state_reg == ST_LOWER) begin
            period_reg <= period_next;
        end
        if (state_reg == ST_DIV_GO && period_reg == 31'd0) begin
            speed_reg <= SPEED_MAX;
        end else if (state_reg == ST_DIV_WAIT && div_rsp.done) begin
            speed_reg <= div_rsp.quotient;
        end else if (state_reg == ST_JUMP) begin
            speed_reg <= speed_fin;
        end
        if (state_reg == ST_MUL_OLD) begin
            prod_reg <= mul_p;
        end
        if (state_reg == ST_MUL_NEW) begin
            slot_reg <= slot_cur;
        end
        if (state_reg == ST_DONE && out_free) begin
            m_tdata_reg <= {6'd0, period_reg, slot_reg, filtered_reg, speed_reg};
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

>>> rtl/cpsm_checker.sv
// Port-level checker for the speed meter, bound to the top level.
`default_nettype none
`include "capture_period_speed_meter_core_defines.svh"

module cpsm_checker
    import cpsm_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [71:0] m_axis_tdata
);

    logic out_stall;
    logic in_take;
    logic out_in_range;
    logic ports_idle;

    assign out_stall    = m_axis_tvalid && !m_axis_tready;
    assign in_take      = s_axis_tvalid && s_axis_tready;
    assign out_in_range = (m_axis_tdata[34:31] < SAMPLE_SLOTS) && !m_axis_tdata[30];
    assign ports_idle   = !m_axis_tvalid && s_axis_tready;

    // a stalled result holds
    `CPSM_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    // one event in work at a time
    `CPSM_ASSERT(a_busy_after_take, in_take |=> !s_axis_tready, "input taken while busy")

    // ring slot stays inside the ring, filter output stays within speed range
    `CPSM_ASSERT(a_slot_range, m_axis_tvalid |-> out_in_range, "slot or filtered speed out of range")

    // reset empties the output and frees the input
    `CPSM_ASSERT_ALWAYS(a_reset_state, !aresetn |=> ports_idle, "bad state after reset")

endmodule

bind capture_period_speed_meter_core cpsm_checker u_cpsm_checker (.*);

`default_nettype wire
